### sv/aeg_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// Used by aeg_front, aeg_cell and adsr_envelope_generator; depends on nothing.
package aeg_pkg;

	// Envelope phase codes as reported on the phase output.
	typedef logic [2:0] phase_t;

	localparam phase_t PH_ATTACK  = 3'd0;
	localparam phase_t PH_DECAY   = 3'd1;
	localparam phase_t PH_SUSTAIN = 3'd2;
	localparam phase_t PH_RELEASE = 3'd3;
	localparam phase_t PH_DONE    = 3'd4;

	// Configuration register indexes.
	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_TOTAL   = 3'd0;
	localparam reg_idx_t REG_ATTACK  = 3'd1;
	localparam reg_idx_t REG_DECAY   = 3'd2;
	localparam reg_idx_t REG_RELEASE = 3'd3;
	localparam reg_idx_t REG_SUSTAIN = 3'd4;

	// Register values after reset, in samples (sustain in level units).
	localparam int RST_TOTAL   = 4410;
	localparam int RST_ATTACK  = 221;
	localparam int RST_DECAY   = 2205;
	localparam int RST_RELEASE = 1985;
	localparam int RST_SUSTAIN = 0;

	// Control that travels with each item down the pipeline.
	typedef struct packed {
		logic   valid;
		phase_t phase;
	} ctl_t;

endpackage

### sv/aeg_front.sv
// Front end of the envelope pipeline: phase decision, numerator product and divisor.
// Depends on aeg_pkg for the phase codes and the control struct.
module aeg_front #(
	parameter int INDEX_BITS = 24,
	parameter int LEVEL_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [INDEX_BITS-1:0]            sample_index,
	input  logic [INDEX_BITS-1:0]            total_len,
	input  logic [INDEX_BITS-1:0]            attack_len,
	input  logic [INDEX_BITS-1:0]            decay_len,
	input  logic [INDEX_BITS-1:0]            release_len,
	input  logic [LEVEL_BITS-1:0]            sustain_lvl,
	output aeg_pkg::ctl_t                    ctl_s3,
	output logic [INDEX_BITS+LEVEL_BITS-1:0] num_s3,
	output logic [INDEX_BITS-1:0]            div_s3
);

	localparam int NW = INDEX_BITS + LEVEL_BITS;
	localparam logic [LEVEL_BITS-1:0] LVL_MAX = {LEVEL_BITS{1'b1}};

	logic                  valid_s1;
	logic [INDEX_BITS-1:0] idx_s1;

	logic                  past_end;
	logic                  in_attack;
	logic                  in_decay;
	logic                  in_sustain;
	logic [INDEX_BITS:0]   decay_end;
	logic [INDEX_BITS:0]   release_start;

	aeg_pkg::phase_t       phase_c;
	logic [LEVEL_BITS-1:0] mul_a_c;
	logic [INDEX_BITS-1:0] mul_b_c;
	logic [INDEX_BITS-1:0] div_c;

	aeg_pkg::ctl_t         ctl_s2;
	logic [LEVEL_BITS-1:0] mul_a_s2;
	logic [INDEX_BITS-1:0] mul_b_s2;
	logic [INDEX_BITS-1:0] div_s2;

	// Capture the sample index on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= sample_index;
	end

	// Phase boundaries; sums are one bit wider so they cannot wrap.
	assign decay_end     = {1'b0, attack_len} + {1'b0, decay_len};
	assign release_start = {1'b0, idx_s1} + {1'b0, release_len};
	assign past_end      = idx_s1 >= total_len;
	assign in_attack     = idx_s1 < attack_len;
	assign in_decay      = {1'b0, idx_s1} < decay_end;
	assign in_sustain    = release_start < {1'b0, total_len};

	// Pick the multiplier operands and divisor for the phase. Past end and
	// sustain divide by one so the level comes straight through the divider.
	// In decay the divider gives the drop below full scale.
	always_comb begin
		priority if (past_end) begin
			phase_c = aeg_pkg::PH_DONE;
			mul_a_c = '0;
			mul_b_c = '0;
			div_c   = INDEX_BITS'(1);
		end else if (in_attack) begin
			phase_c = aeg_pkg::PH_ATTACK;
			mul_a_c = LVL_MAX;
			mul_b_c = idx_s1;
			div_c   = attack_len;
		end else if (in_decay) begin
			phase_c = aeg_pkg::PH_DECAY;
			mul_a_c = LVL_MAX - sustain_lvl;
			mul_b_c = idx_s1 - attack_len;
			div_c   = decay_len;
		end else if (in_sustain) begin
			phase_c = aeg_pkg::PH_SUSTAIN;
			mul_a_c = sustain_lvl;
			mul_b_c = INDEX_BITS'(1);
			div_c   = INDEX_BITS'(1);
		end else begin
			phase_c = aeg_pkg::PH_RELEASE;
			mul_a_c = sustain_lvl;
			mul_b_c = total_len - idx_s1;
			div_c   = release_len;
		end
	end

	// Stage 2 holds the operands, stage 3 the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.phase <= phase_c;
			ctl_s3       <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		mul_a_s2     <= mul_a_c;
		mul_b_s2     <= mul_b_c;
		div_s2       <= div_c;
		num_s3       <= NW'(mul_a_s2) * NW'(mul_b_s2);
		div_s3       <= div_s2;
	end

endmodule

### sv/aeg_cell.sv
// One restoring-division cell: resolves a single quotient bit and passes the rest on.
// Depends on aeg_pkg for the control struct.
module aeg_cell #(
	parameter int INDEX_BITS = 24,
	parameter int LEVEL_BITS = 16,
	parameter int BIT_POS    = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  aeg_pkg::ctl_t                    ctl_in,
	input  logic [INDEX_BITS+LEVEL_BITS-1:0] rem_in,
	input  logic [INDEX_BITS-1:0]            div_in,
	input  logic [LEVEL_BITS-1:0]            quo_in,
	output aeg_pkg::ctl_t                    ctl_q,
	output logic [INDEX_BITS+LEVEL_BITS-1:0] rem_q,
	output logic [INDEX_BITS-1:0]            div_q,
	output logic [LEVEL_BITS-1:0]            quo_q
);

	localparam int NW = INDEX_BITS + LEVEL_BITS;

	logic [NW-1:0]         div_shift;
	logic                  fits;
	logic [LEVEL_BITS-1:0] quo_next;

	// The quotient never reaches 2^LEVEL_BITS, so the shifted divisor fits.
	assign div_shift = NW'(div_in) << BIT_POS;
	assign fits      = rem_in >= div_shift;

	always_comb begin
		quo_next          = quo_in;
		quo_next[BIT_POS] = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	// Subtract when the shifted divisor fits and hand everything to the next cell.
	always_ff @(posedge clk) begin
		rem_q       <= fits ? rem_in - div_shift : rem_in;
		div_q       <= div_in;
		quo_q       <= quo_next;
	end

endmodule

### sv/adsr_envelope_generator.sv
// ADSR envelope generator top level: configuration registers, front end and divider chain.
// Depends on aeg_pkg, aeg_front and aeg_cell.
//
// Each sample index given with start yields one envelope level and phase, marked by
// valid for one cycle at the end of the pipeline. busy stays low, so a new index
// can be started in every cycle and a result leaves in every cycle; the receiver
// must take each result when valid is high. The pipeline is three front stages
// (index capture, phase decision, product) plus one cell per level bit, each cell
// of the restoring divider settling one quotient bit. Register writes take effect
// at the next clock edge and are meant to be made while no sample is in flight.
module adsr_envelope_generator #(
	parameter int  INDEX_BITS = 24,
	parameter int  LEVEL_BITS = 16,
	localparam int DATA_BITS  = (INDEX_BITS > LEVEL_BITS) ? INDEX_BITS : LEVEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [INDEX_BITS-1:0] sample_index,
	output logic                  valid,
	output logic [LEVEL_BITS-1:0] level,
	output logic [2:0]            phase,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [DATA_BITS-1:0]  wr_data
);

	localparam int NW = INDEX_BITS + LEVEL_BITS;
	localparam logic [LEVEL_BITS-1:0] LVL_MAX = {LEVEL_BITS{1'b1}};

	logic [INDEX_BITS-1:0] total_q;
	logic [INDEX_BITS-1:0] attack_q;
	logic [INDEX_BITS-1:0] decay_q;
	logic [INDEX_BITS-1:0] release_q;
	logic [LEVEL_BITS-1:0] sustain_q;

	aeg_pkg::ctl_t         ctl_chain [0:LEVEL_BITS];
	logic [NW-1:0]         rem_chain [0:LEVEL_BITS];
	logic [INDEX_BITS-1:0] div_chain [0:LEVEL_BITS];
	logic [LEVEL_BITS-1:0] quo_chain [0:LEVEL_BITS];

	// Fully pipelined: a start is always accepted.
	assign busy = 1'b0;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= INDEX_BITS'(aeg_pkg::RST_TOTAL);
			attack_q  <= INDEX_BITS'(aeg_pkg::RST_ATTACK);
			decay_q   <= INDEX_BITS'(aeg_pkg::RST_DECAY);
			release_q <= INDEX_BITS'(aeg_pkg::RST_RELEASE);
			sustain_q <= LEVEL_BITS'(aeg_pkg::RST_SUSTAIN);
		end else if (wr_en) begin
			unique case (wr_index)
				aeg_pkg::REG_TOTAL:   total_q   <= wr_data[INDEX_BITS-1:0];
				aeg_pkg::REG_ATTACK:  attack_q  <= wr_data[INDEX_BITS-1:0];
				aeg_pkg::REG_DECAY:   decay_q   <= wr_data[INDEX_BITS-1:0];
				aeg_pkg::REG_RELEASE: release_q <= wr_data[INDEX_BITS-1:0];
				aeg_pkg::REG_SUSTAIN: sustain_q <= wr_data[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Phase decision and numerator product.
	aeg_front #(
		.INDEX_BITS (INDEX_BITS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start),
		.sample_index (sample_index),
		.total_len    (total_q),
		.attack_len   (attack_q),
		.decay_len    (decay_q),
		.release_len  (release_q),
		.sustain_lvl  (sustain_q),
		.ctl_s3       (ctl_chain[0]),
		.num_s3       (rem_chain[0]),
		.div_s3       (div_chain[0])
	);

	assign quo_chain[0] = '0;

	// Divider chain, most significant quotient bit first.
	for (genvar j = 0; j < LEVEL_BITS; j++) begin : g_cell
		aeg_cell #(
			.INDEX_BITS (INDEX_BITS),
			.LEVEL_BITS (LEVEL_BITS),
			.BIT_POS    (LEVEL_BITS - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_chain[j]),
			.rem_in (rem_chain[j]),
			.div_in (div_chain[j]),
			.quo_in (quo_chain[j]),
			.ctl_q  (ctl_chain[j+1]),
			.rem_q  (rem_chain[j+1]),
			.div_q  (div_chain[j+1]),
			.quo_q  (quo_chain[j+1])
		);
	end

	// The last cell's registers drive the result transfer directly. In decay
	// the quotient is the drop below full scale, so it is taken from full scale.
	assign valid = ctl_chain[LEVEL_BITS].valid;
	assign phase = ctl_chain[LEVEL_BITS].phase;
	assign level = (ctl_chain[LEVEL_BITS].phase == aeg_pkg::PH_DECAY)
		? LVL_MAX - quo_chain[LEVEL_BITS] : quo_chain[LEVEL_BITS];

endmodule
